@@ design/srac_pkg.sv @@
// Shared types and constants for the sequence rotate and count block.
package srac_pkg;

  localparam int POS_BITS = 11;
  localparam int VAL_IN_BITS = 16;
  localparam int CNT_OUT_BITS = 11;
  localparam int REQ_BITS = 2;

  localparam logic [REQ_BITS-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_MOVE = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_COUNT = 2'd2;

  localparam logic [1:0] OPD_FIRST = 2'd0;
  localparam logic [1:0] OPD_SECOND = 2'd1;
  localparam logic [1:0] OPD_VALUE = 2'd2;

endpackage

@@ design/srac_if.sv @@
// Valid/ready channel interfaces for requests, responses and configuration.
interface srac_req_if;
  logic                              valid;
  logic                              ready;
  logic [srac_pkg::REQ_BITS-1:0]     req_type;
  logic [srac_pkg::POS_BITS-1:0]     pos_first;
  logic [srac_pkg::POS_BITS-1:0]     pos_second;
  logic [srac_pkg::VAL_IN_BITS-1:0]  value;

  modport source (output valid, req_type, pos_first, pos_second, value, input ready);
  modport sink (input valid, req_type, pos_first, pos_second, value, output ready);
endinterface

interface srac_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [srac_pkg::CNT_OUT_BITS-1:0] match_count;
  logic                              bad_request;

  modport source (output valid, match_count, bad_request, input ready);
  modport sink (input valid, match_count, bad_request, output ready);
endinterface

interface srac_cfg_if;
  logic valid;
  logic ready;
  logic online_decode;

  modport source (output valid, online_decode, input ready);
  modport sink (input valid, online_decode, output ready);
endinterface

@@ design/srac_mod.sv @@
// Bit-serial remainder unit for the operand decode: (t mod n) + 1.
module srac_mod #(
  parameter int TW = 18,
  parameter int CW = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [TW-1:0] t_i,
  input  logic [CW-1:0] n_i,
  output logic          done_o,
  output logic [CW-1:0] res_o
);

  localparam int SC = $clog2(TW + 1);

  logic [TW-1:0] t_q, t_d;
  logic [CW:0]   rem_q, rem_d;
  logic [SC-1:0] step_q, step_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW:0]   rem_sh;

  always_comb begin
    rem_sh = {rem_q[CW-1:0], t_q[TW-1]};
    t_d = t_q;
    rem_d = rem_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      t_d = t_i;
      rem_d = '0;
      step_d = SC'(TW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      t_d = {t_q[TW-2:0], 1'b0};
      rem_d = (rem_sh >= {1'b0, n_i}) ? rem_sh - {1'b0, n_i} : rem_sh;
      step_d = step_q - SC'(1);
      if (step_q == SC'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign res_o = CW'(rem_q + (CW + 1)'(1));

endmodule

@@ design/srac_cell.sv @@
// One storage cell of the chain: holds an element and passes the sweep token down.
module srac_cell #(
  parameter int IDX = 0,
  parameter int AW = 10,
  parameter int CW = 11,
  parameter int VW = 16,
  parameter int SW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_idx_i,
  input  logic [VW-1:0] wr_data_i,
  input  logic          is_move_i,
  input  logic [AW-1:0] lo_i,
  input  logic [AW-1:0] hi_i,
  input  logic [SW-1:0] sought_i,
  input  logic          tok_i,
  input  logic [CW-1:0] cnt_i,
  input  logic [VW-1:0] hold_i,
  input  logic [VW-1:0] prev_i,
  output logic          tok_o,
  output logic [CW-1:0] cnt_o,
  output logic [VW-1:0] hold_o,
  output logic [VW-1:0] val_o
);

  localparam logic [AW-1:0] ME = AW'(IDX);
  localparam int EW = (VW > SW) ? VW : SW;

  logic [VW-1:0] val_q;
  logic          tok_q;
  logic [CW-1:0] cnt_q;
  logic [VW-1:0] hold_q;
  logic          in_rng;
  logic          match;

  assign in_rng = (ME >= lo_i) && (ME <= hi_i);
  assign match = in_rng && !is_move_i && (EW'(val_q) == EW'(sought_i));

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_idx_i == ME)) begin
      val_q <= wr_data_i;
    end else if (tok_i && is_move_i) begin
      if (ME == lo_i) begin
        val_q <= hold_i;
      end else if (in_rng) begin
        val_q <= prev_i;
      end
    end
    cnt_q <= cnt_i + CW'(match);
    hold_q <= (ME == hi_i) ? val_q : hold_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_i;
    end
  end

  assign tok_o = tok_q;
  assign cnt_o = cnt_q;
  assign hold_o = hold_q;
  assign val_o = val_q;

endmodule

@@ design/sequence_rotate_and_count_core.sv @@
// Top level of the sequence rotate and count block.
// The sequence lives in a chain of DEPTH cells. An append transfer writes one cell and
// leaves the core idle for the next request. A move or count launches a token at the top
// cell that walks down the chain one cell per cycle, rotating the segment or accumulating
// matches as it passes. When online decoding is on, each operand (two for a move, three
// for a count) is first decoded on a bit-serial remainder unit. A request rejected on
// acceptance (full store, empty sequence) goes straight to the response; one rejected by
// the position check is answered once its operands are decoded and checked. A result waits
// in the output register while the sink stalls, and a new result holds the core until
// that register frees up. Store entries are undefined until appended; no clearing pass
// runs after reset.
module sequence_rotate_and_count_core #(
  parameter int DEPTH = 1024,
  parameter int VALUE_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  srac_req_if.sink   req_i,
  srac_rsp_if.source rsp_o,
  srac_cfg_if.sink   cfg_i
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (srac_pkg::VAL_IN_BITS > srac_pkg::POS_BITS) ?
                      srac_pkg::VAL_IN_BITS : srac_pkg::POS_BITS;
  localparam int MW = (XW > CW) ? XW : CW;
  localparam int TW = MW + 2;
  localparam int VKEEP = (VALUE_BITS < srac_pkg::VAL_IN_BITS) ?
                         VALUE_BITS : srac_pkg::VAL_IN_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DSTART = 3'd1;
  localparam logic [2:0] S_DWAIT = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_LAUNCH = 3'd4;
  localparam logic [2:0] S_SWEEP = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]    state_q, state_d;
  logic          decode_q;
  logic [CW-1:0] len_q, len_d;
  logic [CW-1:0] last_q, last_d;
  logic [1:0]    opd_q, opd_d;
  logic          move_q, move_d;
  logic [MW-1:0] lo_q, lo_d;
  logic [MW-1:0] hi_q, hi_d;
  logic [MW-1:0] sought_q, sought_d;
  logic [AW-1:0] a_q, a_d;
  logic [AW-1:0] b_q, b_d;
  logic [CW-1:0] res_cnt_q, res_cnt_d;
  logic          res_bad_q, res_bad_d;
  logic          rsp_valid_q, rsp_valid_d;
  logic [CW-1:0] out_cnt_q, out_cnt_d;
  logic          out_bad_q, out_bad_d;

  logic          req_fire;
  logic          wr_en;
  logic          launch;
  logic          mod_start;
  logic          mod_done;
  logic [CW-1:0] mod_res;
  logic [MW-1:0] mod_x;
  logic [TW-1:0] mod_t;
  logic [MW-1:0] pmin, pmax;
  logic          pos_bad;
  logic [MW-1:0] val_keep;

  logic          tok_w  [DEPTH];
  logic [CW-1:0] cnt_w  [DEPTH];
  logic [VALUE_BITS-1:0] hold_w [DEPTH];
  logic [VALUE_BITS-1:0] val_w  [DEPTH];

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign val_keep = MW'(req_i.value[VKEEP-1:0]);
  assign wr_en = req_fire && (req_i.req_type == srac_pkg::REQ_APPEND) &&
                 (len_q < CW'(DEPTH));
  assign launch = (state_q == S_LAUNCH);
  assign mod_start = (state_q == S_DSTART);

  always_comb begin
    case (opd_q)
      srac_pkg::OPD_FIRST:  mod_x = lo_q;
      srac_pkg::OPD_SECOND: mod_x = hi_q;
      default:              mod_x = sought_q;
    endcase
  end
  assign mod_t = TW'(mod_x) + TW'(last_q) + TW'(len_q) - TW'(1);

  assign pmin = (lo_q > hi_q) ? hi_q : lo_q;
  assign pmax = (lo_q > hi_q) ? lo_q : hi_q;
  assign pos_bad = (lo_q == '0) || (hi_q == '0) || (lo_q > MW'(len_q)) ||
                   (hi_q > MW'(len_q));

  always_comb begin
    state_d = state_q;
    len_d = len_q;
    last_d = last_q;
    opd_d = opd_q;
    move_d = move_q;
    lo_d = lo_q;
    hi_d = hi_q;
    sought_d = sought_q;
    a_d = a_q;
    b_d = b_q;
    res_cnt_d = res_cnt_q;
    res_bad_d = res_bad_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    out_cnt_d = out_cnt_q;
    out_bad_d = out_bad_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          lo_d = MW'(req_i.pos_first);
          hi_d = MW'(req_i.pos_second);
          sought_d = val_keep;
          move_d = (req_i.req_type == srac_pkg::REQ_MOVE);
          opd_d = srac_pkg::OPD_FIRST;
          res_cnt_d = '0;
          res_bad_d = 1'b1;
          case (req_i.req_type)
            srac_pkg::REQ_APPEND: begin
              if (wr_en) begin
                len_d = len_q + CW'(1);
              end else begin
                state_d = S_EMIT;
              end
            end
            srac_pkg::REQ_MOVE, srac_pkg::REQ_COUNT: begin
              if (len_q == '0) begin
                state_d = S_EMIT;
              end else if (decode_q) begin
                state_d = S_DSTART;
              end else begin
                state_d = S_CHECK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DSTART: begin
        state_d = S_DWAIT;
      end
      S_DWAIT: begin
        if (mod_done) begin
          case (opd_q)
            srac_pkg::OPD_FIRST:  lo_d = MW'(mod_res);
            srac_pkg::OPD_SECOND: hi_d = MW'(mod_res);
            default:              sought_d = MW'(mod_res);
          endcase
          if ((opd_q == srac_pkg::OPD_VALUE) ||
              (move_q && (opd_q == srac_pkg::OPD_SECOND))) begin
            state_d = S_CHECK;
          end else begin
            opd_d = opd_q + 2'd1;
            state_d = S_DSTART;
          end
        end
      end
      S_CHECK: begin
        a_d = AW'(pmin - MW'(1));
        b_d = AW'(pmax - MW'(1));
        if (pos_bad) begin
          state_d = S_EMIT;
        end else if (move_q && (pmin == pmax)) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_LAUNCH;
        end
      end
      S_LAUNCH: begin
        state_d = S_SWEEP;
      end
      S_SWEEP: begin
        if (tok_w[0]) begin
          if (move_q) begin
            state_d = S_IDLE;
          end else begin
            last_d = cnt_w[0];
            res_cnt_d = cnt_w[0];
            res_bad_d = 1'b0;
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          out_cnt_d = res_cnt_q;
          out_bad_d = res_bad_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      decode_q <= 1'b1;
      len_q <= '0;
      last_q <= '0;
      opd_q <= srac_pkg::OPD_FIRST;
      move_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        decode_q <= cfg_i.online_decode;
      end
      len_q <= len_d;
      last_q <= last_d;
      opd_q <= opd_d;
      move_q <= move_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    sought_q <= sought_d;
    a_q <= a_d;
    b_q <= b_d;
    res_cnt_q <= res_cnt_d;
    res_bad_q <= res_bad_d;
    out_cnt_q <= out_cnt_d;
    out_bad_q <= out_bad_d;
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.match_count = srac_pkg::CNT_OUT_BITS'(out_cnt_q);
  assign rsp_o.bad_request = out_bad_q;

  srac_mod #(
    .TW(TW),
    .CW(CW)
  ) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mod_start),
    .t_i    (mod_t),
    .n_i    (len_q),
    .done_o (mod_done),
    .res_o  (mod_res)
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                  tok_up;
    logic [CW-1:0]         cnt_up;
    logic [VALUE_BITS-1:0] hold_up;
    logic [VALUE_BITS-1:0] prev;

    if (g == DEPTH - 1) begin : g_top
      assign tok_up = launch;
      assign cnt_up = '0;
      assign hold_up = '0;
    end else begin : g_mid
      assign tok_up = tok_w[g+1];
      assign cnt_up = cnt_w[g+1];
      assign hold_up = hold_w[g+1];
    end

    if (g == 0) begin : g_first
      assign prev = '0;
    end else begin : g_rest
      assign prev = val_w[g-1];
    end

    srac_cell #(
      .IDX(g),
      .AW (AW),
      .CW (CW),
      .VW (VALUE_BITS),
      .SW (MW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .wr_en_i  (wr_en),
      .wr_idx_i (AW'(len_q)),
      .wr_data_i(VALUE_BITS'(req_i.value[VKEEP-1:0])),
      .is_move_i(move_q),
      .lo_i     (a_q),
      .hi_i     (b_q),
      .sought_i (sought_q),
      .tok_i    (tok_up),
      .cnt_i    (cnt_up),
      .hold_i   (hold_up),
      .prev_i   (prev),
      .tok_o    (tok_w[g]),
      .cnt_o    (cnt_w[g]),
      .hold_o   (hold_w[g]),
      .val_o    (val_w[g])
    );
  end

endmodule
